/* rtl/core/chbd_pkg.sv */
// Shared types, codes and helpers for the chunked body decoder.
package chbd_pkg;

    localparam int unsigned LINE_BUFFER_BYTES_DEF = 32;
    localparam int unsigned BODY_LIMIT_DEF        = 32 * 1024 * 1024;

    localparam int unsigned BODY_W  = 26;
    localparam int unsigned LINE_W  = 5;
    localparam int unsigned SIZE_W  = 28;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [BODY_W-1:0] MAX_BODY_RST = BODY_W'(BODY_LIMIT_DEF);
    localparam logic [LINE_W-1:0] MAX_LINE_RST = LINE_W'(31);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE = 1'd1;

    // decoder phases
    localparam logic [1:0] PH_SIZE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_TAIL = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] K_FRAMING   = 3'd0;
    localparam logic [KIND_W-1:0] K_PAYLOAD   = 3'd1;
    localparam logic [KIND_W-1:0] K_COMPLETE  = 3'd2;
    localparam logic [KIND_W-1:0] K_LINE_LONG = 3'd3;
    localparam logic [KIND_W-1:0] K_TOO_LARGE = 3'd4;
    localparam logic [KIND_W-1:0] K_IGNORED   = 3'd5;

    // request types
    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_START = 1'b1;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    localparam logic [SIZE_W-1:0] SIZE_SAT   = {SIZE_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_SHIFT_MAX = SIZE_SAT >> 4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload;
        logic              final_flag;
        logic [BODY_W-1:0] count;
    } t_result;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [BYTE_W-1:0] b);
        t_hex h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.value = 4'(b - 8'h37);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

/* rtl/core/http_chunked_body_decoder.sv */
// Top level of the HTTP chunked body decoder with output register and skid stage.
// An accepted request's result is registered in the output register or, while
// the output stalls, in the single skid entry, which lets one more request in.
// Throughput: one request per cycle while the skid entry is free; the single-pass
// decode logic between the decoder state and the output register sets that figure.
// Reset (synchronous, active low) clears decoder state, restores the config
// registers to their defaults and empties the output and skid stages.
module http_chunked_body_decoder #(
    parameter int unsigned LINE_BUFFER_BYTES = chbd_pkg::LINE_BUFFER_BYTES_DEF,
    parameter int unsigned BODY_LIMIT        = chbd_pkg::BODY_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [chbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [chbd_pkg::BODY_W-1:0]     i_cfg_data,
    // request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_req_type,
    input  logic [chbd_pkg::BYTE_W-1:0]     i_data_byte,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [chbd_pkg::KIND_W-1:0]     o_out_kind,
    output logic [chbd_pkg::BYTE_W-1:0]     o_payload_byte,
    output logic                            o_body_final,
    output logic [chbd_pkg::BODY_W-1:0]     o_body_count
);

    logic              accept;
    logic              take;
    chbd_pkg::t_result core_res;

    logic              r_out_valid;
    logic              r_skid_valid;
    chbd_pkg::t_result r_out;
    chbd_pkg::t_result r_skid;

    // a request is taken whenever the skid entry is free
    assign o_ready = !r_skid_valid;
    assign accept  = i_valid && o_ready;
    assign take    = r_out_valid && i_ready;

    chbd_core #(
        .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES),
        .BODY_LIMIT        (BODY_LIMIT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .o_result    (core_res)
    );

    // output register: refills from skid first to keep order, else from the core
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (take || !r_out_valid) begin
                r_out_valid  <= r_skid_valid || accept;
                r_skid_valid <= 1'b0;
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : core_res;
        end
        if (accept && r_out_valid && !take) begin
            r_skid <= core_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_kind     = r_out.kind;
    assign o_payload_byte = r_out.payload;
    assign o_body_final   = r_out.final_flag;
    assign o_body_count   = r_out.count;

endmodule

/* rtl/core/chbd_core.sv */
// Decoder state, configuration registers and per-byte next-state logic.
module chbd_core #(
    parameter int unsigned LINE_BUFFER_BYTES = chbd_pkg::LINE_BUFFER_BYTES_DEF,
    parameter int unsigned BODY_LIMIT        = chbd_pkg::BODY_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [chbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [chbd_pkg::BODY_W-1:0]     i_cfg_data,
    input  logic                            i_accept,
    input  logic                            i_req_type,
    input  logic [chbd_pkg::BYTE_W-1:0]     i_data_byte,
    output chbd_pkg::t_result               o_result
);

    localparam int unsigned LCAP_W = $clog2(LINE_BUFFER_BYTES);
    localparam int unsigned LW     = (LCAP_W > chbd_pkg::LINE_W) ? LCAP_W : chbd_pkg::LINE_W;
    localparam int unsigned BCAP_W = $clog2(BODY_LIMIT + 1);
    localparam int unsigned BW     = (BCAP_W > chbd_pkg::BODY_W) ? BCAP_W : chbd_pkg::BODY_W;
    localparam logic [LW-1:0] LINE_CAP  = LW'(LINE_BUFFER_BYTES - 1);
    localparam logic [BW-1:0] BODY_CEIL = BW'(BODY_LIMIT);

    logic [chbd_pkg::BODY_W-1:0] r_max_body;
    logic [chbd_pkg::LINE_W-1:0] r_max_line;

    logic [1:0]                  r_phase,      n_phase;
    logic [chbd_pkg::SIZE_W-1:0] r_size_accum, n_size_accum;
    logic                        r_digits_end, n_digits_end;
    logic [chbd_pkg::LINE_W-1:0] r_line_count, n_line_count;
    logic [chbd_pkg::SIZE_W-1:0] r_chunk_rem,  n_chunk_rem;
    logic [chbd_pkg::BODY_W-1:0] r_total,      n_total;

    logic [LW-1:0]     line_lim;
    logic [BW-1:0]     body_lim;
    logic [LW-1:0]     line_reg_ext;
    logic [BW-1:0]     body_reg_ext;
    chbd_pkg::t_hex    hex;
    logic [chbd_pkg::SIZE_W-1:0] chunk_dec;

    assign line_reg_ext = LW'(r_max_line);
    assign body_reg_ext = BW'(r_max_body);
    assign line_lim = (line_reg_ext < LINE_CAP) ? line_reg_ext : LINE_CAP;
    assign body_lim = (body_reg_ext < BODY_CEIL) ? body_reg_ext : BODY_CEIL;
    assign hex = chbd_pkg::hex_decode(i_data_byte);
    assign chunk_dec = (r_chunk_rem != '0) ? r_chunk_rem - 1'b1 : r_chunk_rem;

    always_comb begin
        n_phase      = r_phase;
        n_size_accum = r_size_accum;
        n_digits_end = r_digits_end;
        n_line_count = r_line_count;
        n_chunk_rem  = r_chunk_rem;
        n_total      = r_total;
        o_result.kind       = chbd_pkg::K_FRAMING;
        o_result.payload    = '0;
        o_result.final_flag = 1'b0;

        if (i_req_type == chbd_pkg::REQ_START) begin
            n_phase      = chbd_pkg::PH_SIZE;
            n_size_accum = '0;
            n_digits_end = 1'b0;
            n_line_count = '0;
            n_chunk_rem  = '0;
            n_total      = '0;
        end else begin
            unique case (r_phase)
                chbd_pkg::PH_SIZE: begin
                    if (LW'(r_line_count) >= line_lim) begin
                        n_phase             = chbd_pkg::PH_END;
                        o_result.kind       = chbd_pkg::K_LINE_LONG;
                        o_result.final_flag = 1'b1;
                    end else if (i_data_byte == chbd_pkg::CH_LF) begin
                        n_size_accum = '0;
                        n_digits_end = 1'b0;
                        n_line_count = '0;
                        if (r_size_accum == '0) begin
                            n_phase             = chbd_pkg::PH_END;
                            o_result.kind       = chbd_pkg::K_COMPLETE;
                            o_result.final_flag = 1'b1;
                        end else begin
                            n_chunk_rem = r_size_accum;
                            n_phase     = chbd_pkg::PH_DATA;
                        end
                    end else begin
                        n_line_count = r_line_count + 1'b1;
                        if (!r_digits_end && hex.is_hex) begin
                            // saturate instead of wrapping on oversize values
                            if (r_size_accum > chbd_pkg::SIZE_SHIFT_MAX) begin
                                n_size_accum = chbd_pkg::SIZE_SAT;
                            end else begin
                                n_size_accum = {r_size_accum[chbd_pkg::SIZE_W-5:0], hex.value};
                            end
                        end else begin
                            n_digits_end = 1'b1;
                        end
                    end
                end
                chbd_pkg::PH_DATA: begin
                    if (BW'(r_total) >= body_lim) begin
                        n_phase             = chbd_pkg::PH_END;
                        o_result.kind       = chbd_pkg::K_TOO_LARGE;
                        o_result.final_flag = 1'b1;
                    end else begin
                        n_total          = r_total + 1'b1;
                        n_chunk_rem      = chunk_dec;
                        o_result.kind    = chbd_pkg::K_PAYLOAD;
                        o_result.payload = i_data_byte;
                        if (chunk_dec == '0) begin
                            n_phase = chbd_pkg::PH_TAIL;
                        end
                    end
                end
                chbd_pkg::PH_TAIL: begin
                    if (i_data_byte == chbd_pkg::CH_LF) begin
                        n_phase      = chbd_pkg::PH_SIZE;
                        n_size_accum = '0;
                        n_digits_end = 1'b0;
                        n_line_count = '0;
                    end
                end
                chbd_pkg::PH_END: begin
                    o_result.kind = chbd_pkg::K_IGNORED;
                end
            endcase
        end
        o_result.count = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body   <= chbd_pkg::MAX_BODY_RST;
            r_max_line   <= chbd_pkg::MAX_LINE_RST;
            r_phase      <= chbd_pkg::PH_SIZE;
            r_size_accum <= '0;
            r_digits_end <= 1'b0;
            r_line_count <= '0;
            r_chunk_rem  <= '0;
            r_total      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == chbd_pkg::REG_MAX_BODY) begin
                    r_max_body <= i_cfg_data;
                end else if (i_cfg_idx == chbd_pkg::REG_MAX_LINE) begin
                    r_max_line <= i_cfg_data[chbd_pkg::LINE_W-1:0];
                end
            end
            if (i_accept) begin
                r_phase      <= n_phase;
                r_size_accum <= n_size_accum;
                r_digits_end <= n_digits_end;
                r_line_count <= n_line_count;
                r_chunk_rem  <= n_chunk_rem;
                r_total      <= n_total;
            end
        end
    end

endmodule
